// ----- design/aging_neighbor_table_top_defines.svh -----
// ----------------------------------------------------------------------------
// aging neighbor table assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef AGING_NEIGHBOR_TABLE_TOP_DEFINES_SVH
`define AGING_NEIGHBOR_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define ANT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ANT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ant_pkg.sv -----
// ----------------------------------------------------------------------------
// aging neighbor table package
// table geometry, item and entry types, action codes and the memory port bundle
// ----------------------------------------------------------------------------
`default_nettype none

package ant_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam logic [15:0] EXPIRY_RESET = 16'd32;

    typedef enum logic [1:0] {
        ACT_REFRESH   = 2'd0,
        ACT_APPEND    = 2'd1,
        ACT_OVERWRITE = 2'd2,
        ACT_SWEEP     = 2'd3
    } t_action;

    typedef struct packed {
        logic        mode;
        logic [7:0]  neighbor_id;
        logic [7:0]  distance_mm;
        logic [7:0]  reported_count;
        logic [31:0] now;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [3:0]  slot;
        logic [4:0]  live_count;
        logic [4:0]  removed;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] stamp;
        logic [7:0]  distance;
        logic [7:0]  their_count;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] rd_addr;
        t_entry           wr_data;
    } t_mem_req;

endpackage

`default_nettype wire

// ----- design/ant_mem.sv -----
// ----------------------------------------------------------------------------
// aging neighbor table entry memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ant_mem (
    input  wire logic              i_clk,
    input  wire ant_pkg::t_mem_req i_req,
    output ant_pkg::t_entry        o_rd_data
);
    import ant_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- design/ant_cmp.sv -----
// ----------------------------------------------------------------------------
// aging neighbor table compare unit
// id match for an update, age-over-expiry test for a sweep
// ----------------------------------------------------------------------------
`default_nettype none

module ant_cmp (
    input  wire logic            i_mode,
    input  wire logic [7:0]      i_key_id,
    input  wire logic [31:0]     i_now,
    input  wire logic [15:0]     i_expiry,
    input  wire ant_pkg::t_entry i_entry,
    output logic                 o_hit
);
    import ant_pkg::*;

    logic [31:0] age;

    // age wraps modulo 2^32
    assign age   = i_now - i_entry.stamp;
    assign o_hit = i_mode ? (age > {16'd0, i_expiry}) : (i_entry.id == i_key_id);

endmodule

`default_nettype wire

// ----- design/ant_ctrl.sv -----
// ----------------------------------------------------------------------------
// aging neighbor table sequencer
// walks the entries one per cycle for search and sweep (a sweep removal adds a step), issues memory writes
// ----------------------------------------------------------------------------
`default_nettype none

module ant_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire ant_pkg::t_in_item i_in,
    input  wire ant_pkg::t_entry   i_rd_data,
    input  wire logic              i_hit,
    output logic                   o_busy,
    output ant_pkg::t_in_item      o_item,
    output ant_pkg::t_mem_req      o_req,
    output logic                   o_done,
    output ant_pkg::t_out_item     o_out
);
    import ant_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_TEST  = 5'b00100,
        S_LAST  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    t_in_item         r_item, n_item;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_removed, n_removed;
    logic [IDX_W-1:0] r_slot, n_slot;
    t_action          r_action, n_action;
    logic             r_done, n_done;

    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] idx_p1;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] miss_slot;
    t_action          miss_action;
    logic [CNT_W-1:0] miss_cnt;

    assign cnt_m1   = r_cnt - CNT_W'(1);
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign idx_p1   = {1'b0, r_idx} + CNT_W'(1);

    // placement on a search miss: append if room, else overwrite the last slot
    always_comb begin
        if (r_cnt < CNT_W'(TABLE_DEPTH)) begin
            miss_slot   = r_cnt[IDX_W-1:0];
            miss_action = ACT_APPEND;
            miss_cnt    = r_cnt + CNT_W'(1);
        end else begin
            miss_slot   = IDX_W'(TABLE_DEPTH - 1);
            miss_action = ACT_OVERWRITE;
            miss_cnt    = r_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_removed = r_removed;
        n_slot    = r_slot;
        n_action  = r_action;
        n_done    = 1'b0;

        o_req.we      = 1'b0;
        o_req.wr_addr = r_slot;
        o_req.rd_addr = r_idx;
        o_req.wr_data = '{id: r_item.neighbor_id, stamp: r_item.now,
                          distance: r_item.distance_mm,
                          their_count: r_item.reported_count};

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item    = i_in;
                    n_removed = '0;
                    n_slot    = '0;
                    if (!i_in.mode) begin
                        if (r_cnt == '0) begin
                            n_slot   = miss_slot;
                            n_action = miss_action;
                            n_cnt    = miss_cnt;
                            n_state  = S_WRITE;
                        end else begin
                            n_idx   = '0;
                            n_state = S_READ;
                        end
                    end else begin
                        n_action = ACT_SWEEP;
                        if (r_cnt == '0) begin
                            n_done = 1'b1;
                        end else begin
                            n_idx   = last_idx;
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_TEST;
            end
            S_TEST: begin
                if (!r_item.mode) begin
                    if (i_hit) begin
                        n_slot   = r_idx;
                        n_action = ACT_REFRESH;
                        n_state  = S_WRITE;
                    end else if (idx_p1 < r_cnt) begin
                        n_idx         = idx_p1[IDX_W-1:0];
                        o_req.rd_addr = idx_p1[IDX_W-1:0];
                    end else begin
                        n_slot   = miss_slot;
                        n_action = miss_action;
                        n_cnt    = miss_cnt;
                        n_state  = S_WRITE;
                    end
                end else begin
                    if (i_hit) begin
                        // expired: fetch the current last live entry to move down
                        o_req.rd_addr = last_idx;
                        n_state       = S_LAST;
                    end else if (r_idx == '0) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx         = r_idx - IDX_W'(1);
                        o_req.rd_addr = r_idx - IDX_W'(1);
                    end
                end
            end
            S_LAST: begin
                o_req.we      = 1'b1;
                o_req.wr_addr = r_idx;
                o_req.wr_data = i_rd_data;
                n_cnt         = cnt_m1;
                n_removed     = r_removed + CNT_W'(1);
                if (r_idx == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx         = r_idx - IDX_W'(1);
                    o_req.rd_addr = r_idx - IDX_W'(1);
                    n_state       = S_TEST;
                end
            end
            S_WRITE: begin
                o_req.we = 1'b1;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_idx     <= n_idx;
        r_removed <= n_removed;
        r_slot    <= n_slot;
        r_action  <= n_action;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_item = r_item;
    assign o_done = r_done;
    assign o_out  = '{action: r_action, slot: 4'(r_slot), live_count: 5'(r_cnt),
                      removed: 5'(r_removed)};

endmodule

`default_nettype wire

// ----- design/aging_neighbor_table_top.sv -----
// ----------------------------------------------------------------------------
// aging neighbor table
// neighbor table with id search, refresh/append/overwrite and timed expiry sweep
// ----------------------------------------------------------------------------
// usage:
//   an item is taken when start is high and busy is low; busy stays high
//   while the item is worked on and is low again in the o_done cycle (a sweep
//   of an empty table never raises it). o_done strobes for one cycle with
//   o_out; the receiver must take it then, it cannot stall the block.
//   the expiry register is written over the cfg channel (valid/ready, ready
//   always high); the user must do so only while the block is idle, which
//   the block itself does not enforce. reset value 32 ticks.
// operation: an update searches from slot 0 up to a hit or the last live
//   entry, then writes (an empty table goes straight to the write); a sweep
//   walks from the last live entry down to slot 0 (none on an empty table).
//   the entry memory gives one read per cycle, which sets the one entry
//   per cycle walk; a removal adds a step to fetch the current last entry.
// reset (synchronous, active low) empties the table and restores the
// expiry register; entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_neighbor_table_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ant_pkg::t_in_item  i_in,
    output logic                    o_done,
    output ant_pkg::t_out_item      o_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [15:0]        i_cfg_data
);
    import ant_pkg::*;

    `include "aging_neighbor_table_top_defines.svh"

    logic [15:0] r_expiry;
    t_in_item    item;
    t_mem_req    mem_req;
    t_entry      rd_data;
    logic        hit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= EXPIRY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_expiry <= i_cfg_data;
        end
    end

    ant_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_in      (i_in),
        .i_rd_data (rd_data),
        .i_hit     (hit),
        .o_busy    (busy),
        .o_item    (item),
        .o_req     (mem_req),
        .o_done    (o_done),
        .o_out     (o_out)
    );

    ant_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    ant_cmp u_cmp (
        .i_mode    (item.mode),
        .i_key_id  (item.neighbor_id),
        .i_now     (item.now),
        .i_expiry  (r_expiry),
        .i_entry   (rd_data),
        .o_hit     (hit)
    );

    // an accepted transfer makes the block busy, or finishes at once on an empty sweep
    `ANT_ASSERT_NEXT(a_start_busy, start && !busy, busy || o_done, "accepted item dropped")
    `ANT_ASSERT_NOW(a_count_max, o_done, o_out.live_count <= 5'(TABLE_DEPTH), "count too large")
    `ANT_ASSERT_NOW(a_update_removed, o_done && (o_out.action != ACT_SWEEP), o_out.removed == '0, "update reported removals")
    `ANT_ASSERT_NOW(a_append_slot, o_done && (o_out.action == ACT_APPEND), o_out.live_count == ({1'b0, o_out.slot} + 5'd1), "append slot not at end")

endmodule

`default_nettype wire

// ----- test/neighbor_table_check.sv -----
// ----------------------------------------------------------------------------
// neighbor table result checker
// watches the item, result and expiry channels of the aging neighbor table,
// keeps its own copy of the table, predicts each result and compares it
// field by field with what the block puts out
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_table_check
    import ant_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire t_in_item    i_in,
    input  wire logic        i_done,
    input  wire t_out_item   i_out,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results,
    output int               o_expired
);

    t_entry             tbl [TABLE_DEPTH];
    logic [CNT_W-1:0]   live;
    logic [15:0]        expiry;
    t_out_item          awaited_results [$];
    int                 fails;
    int                 results;
    int                 expired;

    // applies one item to the local table and returns the result it should give
    function automatic t_out_item apply_item(input t_in_item it);
        t_out_item  res;
        int         j;
        int         hit_slot;
        logic [31:0] age;
        res = '0;
        if (!it.mode) begin
            hit_slot = -1;
            for (j = 0; j < live; j++) begin
                if (hit_slot < 0 && tbl[j].id == it.neighbor_id) begin
                    hit_slot = j;
                end
            end
            if (hit_slot >= 0) begin
                res.action = ACT_REFRESH;
            end else if (live < TABLE_DEPTH) begin
                hit_slot   = live;
                live       = live + 1'b1;
                res.action = ACT_APPEND;
            end else begin
                hit_slot   = live - 1;
                res.action = ACT_OVERWRITE;
            end
            tbl[hit_slot] = '{id: it.neighbor_id, stamp: it.now,
                              distance: it.distance_mm, their_count: it.reported_count};
            res.slot = hit_slot[3:0];
        end else begin
            // walk last to first; an expired entry takes the current last one
            for (j = int'(live) - 1; j >= 0; j--) begin
                age = it.now - tbl[j].stamp;
                if (age > {16'd0, expiry}) begin
                    tbl[j]      = tbl[live - 1'b1];
                    live        = live - 1'b1;
                    res.removed = res.removed + 1'b1;
                end
            end
            res.action = ACT_SWEEP;
            res.slot   = '0;
        end
        res.live_count = live;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (!i_rst_n) begin
            live   = '0;
            expiry = EXPIRY_RESET;
            awaited_results.delete();
        end else begin
            // a result leaving this cycle belongs to an earlier item
            if (i_done) begin
                if (awaited_results.size() == 0) begin
                    $error("result with nothing awaited: action %0d slot %0d",
                           i_out.action, i_out.slot);
                    fails++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    results++;
                    expired += exp_res.removed;
                    if (i_out.action !== exp_res.action) begin
                        $error("action mismatch: expected %0d, got %0d",
                               exp_res.action, i_out.action);
                        fails++;
                    end
                    if (i_out.slot !== exp_res.slot) begin
                        $error("slot mismatch: expected %0d, got %0d",
                               exp_res.slot, i_out.slot);
                        fails++;
                    end
                    if (i_out.live_count !== exp_res.live_count) begin
                        $error("live_count mismatch: expected %0d, got %0d",
                               exp_res.live_count, i_out.live_count);
                        fails++;
                    end
                    if (i_out.removed !== exp_res.removed) begin
                        $error("removed mismatch: expected %0d, got %0d",
                               exp_res.removed, i_out.removed);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_results.push_back(apply_item(i_in));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                expiry = i_cfg_data;
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
        o_results    <= results;
        o_expired    <= expired;
    end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// aging neighbor table testbench
// directed items for the table edges (empty sweep, full table, exact age,
// tick wrap), then random phases under several expiry settings with small id
// pools so the table fills, refreshes and drains; a checker beside the block
// predicts and compares every result
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import ant_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 215;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    t_in_item    i_in        = '0;
    logic        o_done;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data  = '0;

    int fail_count;
    int pending;
    int results;
    int expired;
    int settings_used = 1;
    int idle_cycles   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    aging_neighbor_table_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_done      (o_done),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    neighbor_table_check table_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_in         (i_in),
        .i_done       (o_done),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_expired    (expired)
    );

    function automatic t_in_item heard(input logic [7:0] id, input logic [7:0] range_mm,
                                       input logic [7:0] rep, input logic [31:0] tick);
        return '{mode: 1'b0, neighbor_id: id, distance_mm: range_mm,
                 reported_count: rep, now: tick};
    endfunction

    function automatic t_in_item sweep_at(input logic [31:0] tick);
        return '{mode: 1'b1, neighbor_id: 8'($urandom), distance_mm: 8'($urandom),
                 reported_count: 8'($urandom), now: tick};
    endfunction

    // holds start high until the block takes the item
    task automatic issue(input t_in_item it);
        @(negedge i_clk);
        start <= 1'b1;
        i_in  <= it;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic rest(input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic write_expiry(input logic [15:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // ids mostly from a pool of 20 so the table fills; ticks advance on the
    // scale of the expiry so sweeps both keep and drop entries
    task automatic run_phase(input logic [15:0] expiry, input logic [31:0] tick_start,
                             input logic [7:0] pool_base);
        t_in_item    it;
        logic [31:0] tick;
        int          step_max;
        bit          gaps_on;
        write_expiry(expiry);
        tick     = tick_start;
        step_max = int'(expiry) / 3 + 3;
        gaps_on  = 1'b1;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
            if ($urandom_range(0, 99) == 0) settle();
            tick = tick + $urandom_range(0, step_max);
            it.mode           = ($urandom_range(0, 4) == 0);
            it.neighbor_id    = ($urandom_range(0, 6) == 0) ? 8'($urandom)
                                : pool_base + 8'($urandom_range(0, 19));
            it.distance_mm    = 8'($urandom);
            it.reported_count = 8'($urandom);
            it.now            = ($urandom_range(0, 19) == 0) ? $urandom : tick;
            issue(it);
            rest(gaps_on ? $urandom_range(0, 10) : 0);
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, expiry at its reset value of 32
        issue(sweep_at(32'd0));
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            issue(heard(8'(k * 17), (k == 0) ? 8'd0 : (k == 15) ? 8'd255 : 8'($urandom),
                        (k == 0) ? 8'd0 : (k == 15) ? 8'd255 : 8'($urandom), 32'd100));
        end
        issue(heard(8'd255, 8'd200, 8'd7, 32'd100));        // refresh last slot
        issue(heard(8'd1, 8'd50, 8'd3, 32'd100));           // miss on a full table
        issue(sweep_at(32'd132));                           // age equals expiry, kept
        issue(sweep_at(32'd133));                           // all one tick too old
        issue(heard(8'd7, 8'd10, 8'd1, 32'hFFFF_FFF0));
        issue(heard(8'd8, 8'd20, 8'd2, 32'd5));
        issue(sweep_at(32'd10));                            // age across the wrap, kept
        issue(sweep_at(32'hFFFF_FFF8));                     // stamp in the future expires

        run_phase(16'd1, $urandom, 8'($urandom));
        run_phase(16'd65535, 32'hFFF0_0000, 8'd240);
        run_phase(16'd0, $urandom, 8'($urandom));
        run_phase(16'($urandom_range(2, 2000)), $urandom, 8'd0);
        run_phase(16'($urandom), $urandom, 8'($urandom));
        run_phase(16'd32, $urandom, 8'($urandom));

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("checked %0d results under %0d expiry settings", results, settings_used);
        $display("sweeps expired %0d entries in total", expired);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // ends a hung run: no transfer on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
